FILE: rtl/core/hpd_pkg.sv
package hpd_pkg;

    // field and register widths
    localparam int YAW_W      = 16;
    localparam int TGT_W      = 16;
    localparam int BASE_W     = 13;
    localparam int RPM_W      = 16;
    localparam int GAIN_W     = 12;
    localparam int CMD_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEADING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd5;

    // register reset values
    localparam logic signed [TGT_W-1:0] TARGET_RESET = 16'sd640;
    localparam logic [BASE_W-1:0]       BASE_RESET   = 13'd154;
    localparam logic [RPM_W-1:0]        RPM_RESET    = 16'd5000;
    localparam logic [GAIN_W-1:0]       GAIN_P_RESET = 12'd282;
    localparam logic [GAIN_W-1:0]       GAIN_I_RESET = 12'd26;
    localparam logic [GAIN_W-1:0]       GAIN_D_RESET = 12'd179;

    // angle and loop limits, 1/64 degree based
    localparam int HALF_TURN   = 11520;
    localparam int FULL_TURN   = 23040;
    localparam int DERIV_LIM   = 640;
    localparam int INTEG_LIM   = 25600;
    localparam int SPEED_LIMIT = 2000;
    localparam int PID_LIM_BASE = 51200;

    // motor geometry scale factors
    localparam int KW_W = 30;
    localparam int KV_W = 29;
    localparam logic [KW_W-1:0] KW_Q16 = 30'd564892008;
    localparam logic [KV_W-1:0] KV_Q8  = 29'd358726115;
    localparam logic [40:0]     SPEED_FULL = 41'd65536000;
    localparam logic [18:0]     V0_DIVISOR = 19'd125;

    typedef logic signed [CMD_W-1:0] cmd_t;

endpackage

FILE: rtl/core/heading_pid_differential_drive.sv
// heading pid controller for a differential-drive base
//
// input channel (s_valid/s_ready/s_yaw): one measured yaw sample per beat,
// 1/64 degree, two's complement. result channel (m_valid/m_ready): turn
// command, speed command and overspeed flag, one result beat per sample.
// configuration: cfg_wr_en/cfg_index/cfg_wdata write one register per cycle;
// the user writes only while no sample is in flight, the block does not enforce it.
//
// the block works on one sample at a time; a new sample can be taken in the
// cycle after the result is loaded. the work is done in steps: 12 steps for
// the pid gains, then, on the shared bit-serial multiply/divide unit, three
// multiplies (30, 13, 29 steps) and three 40-step restoring divides.
//
// reset (aresetn low, synchronous) restores the register defaults, clears the
// stored error and integral and drops m_valid. a result waits in the
// output register while m_ready is low; the next sample can be accepted and
// worked on meanwhile, and its result is held back until the register frees.
module heading_pid_differential_drive #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [hpd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hpd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [hpd_pkg::YAW_W-1:0]      s_yaw,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [hpd_pkg::CMD_W-1:0]      m_turn_command,
    output logic signed [hpd_pkg::CMD_W-1:0]      m_speed_command,
    output logic                                  m_overspeed
);
    import hpd_pkg::*;

    localparam int ACC_W  = 64;
    localparam int OPA_W  = 40;
    localparam int DIV_W  = 40;
    localparam int DVSR_W = 19;
    localparam int CNT_W  = 6;
    localparam int PID_W  = 36;
    localparam int PROD_SHIFT = GAIN_FRAC_BITS + 9;   // 2560 = 5 * 2^9
    localparam logic signed [PID_W-1:0] PID_LIM =
        PID_W'(PID_LIM_BASE * (1 << GAIN_FRAC_BITS));

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PID    = 4'd1;
    localparam logic [3:0] ST_PCLAMP = 4'd2;
    localparam logic [3:0] ST_MUL1   = 4'd3;
    localparam logic [3:0] ST_DIV1   = 4'd4;
    localparam logic [3:0] ST_MUL2   = 4'd5;
    localparam logic [3:0] ST_DIV2   = 4'd6;
    localparam logic [3:0] ST_MUL3   = 4'd7;
    localparam logic [3:0] ST_DIV3   = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    // configuration
    logic signed [TGT_W-1:0] target_reg;
    logic [BASE_W-1:0]       base_reg;
    logic [RPM_W-1:0]        rpm_reg;
    logic [GAIN_W-1:0]       gain_p_reg;
    logic [GAIN_W-1:0]       gain_i_reg;
    logic [GAIN_W-1:0]       gain_d_reg;

    // controller state
    logic [3:0]              state_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [15:0]      prev_err_reg;
    logic signed [15:0]      integ_reg;
    logic signed [21:0]      e40_reg;
    logic signed [15:0]      d40_reg;
    logic signed [PID_W-1:0] pid_reg;

    // shared serial unit
    logic [ACC_W-1:0]        acc_reg;
    logic [OPA_W-1:0]        opa_reg;
    logic [KW_W-1:0]         opb_reg;
    logic [DVSR_W-1:0]       rem_reg;
    logic [DVSR_W-1:0]       dvsr_reg;
    logic                    neg_w_reg;
    logic                    neg_v_reg;
    logic signed [24:0]      w_reg;
    logic signed [40:0]      v_reg;

    // output register
    logic                    m_valid_reg;
    cmd_t                    turn_reg;
    cmd_t                    speed_reg;
    logic                    over_reg;

    // front end: error, derivative, integral
    logic signed [17:0] diff_raw;
    logic signed [17:0] diff_wrap;
    logic signed [15:0] err;
    logic signed [16:0] err_delta;
    logic signed [21:0] deriv20;
    logic signed [10:0] deriv;
    logic signed [17:0] integ_sum;
    logic signed [15:0] integ_new;

    always_comb begin
        diff_raw = {{2{s_yaw[15]}}, s_yaw} - {{2{target_reg[15]}}, target_reg};
        if (diff_raw > HALF_TURN) begin
            diff_wrap = diff_raw - 18'sd23040;
        end else if (diff_raw < -HALF_TURN) begin
            diff_wrap = diff_raw + 18'sd23040;
        end else begin
            diff_wrap = diff_raw;
        end
        if (diff_wrap > 32767) begin
            err = 16'sh7fff;
        end else if (diff_wrap < -32768) begin
            err = -16'sh8000;
        end else begin
            err = diff_wrap[15:0];
        end
        err_delta = {err[15], err} - {prev_err_reg[15], prev_err_reg};
        deriv20 = ({{5{err_delta[16]}}, err_delta} <<< 4)
                + ({{5{err_delta[16]}}, err_delta} <<< 2);
        if (deriv20 > DERIV_LIM) begin
            deriv = 11'sd640;
        end else if (deriv20 < -DERIV_LIM) begin
            deriv = -11'sd640;
        end else begin
            deriv = deriv20[10:0];
        end
        integ_sum = {{2{integ_reg[15]}}, integ_reg} + {{2{err[15]}}, err}
                  + {{2{prev_err_reg[15]}}, prev_err_reg};
        if (integ_sum > INTEG_LIM) begin
            integ_new = 16'sd25600;
        end else if (integ_sum < -INTEG_LIM) begin
            integ_new = -16'sd25600;
        end else begin
            integ_new = integ_sum[15:0];
        end
    end

    // pid accumulate, one gain bit per cycle from the msb
    logic signed [PID_W-1:0] pid_term;
    logic signed [PID_W-1:0] pid_step;
    logic signed [PID_W-1:0] pid_clamped;
    logic [PID_W-1:0]        pid_mag;

    always_comb begin
        pid_term = '0;
        if (gain_p_reg[cnt_reg[3:0]]) begin
            pid_term = pid_term + PID_W'(e40_reg);
        end
        if (gain_i_reg[cnt_reg[3:0]]) begin
            pid_term = pid_term + PID_W'(integ_reg);
        end
        if (gain_d_reg[cnt_reg[3:0]]) begin
            pid_term = pid_term + PID_W'(d40_reg);
        end
        pid_step = (pid_reg <<< 1) + pid_term;
        if (pid_reg > PID_LIM) begin
            pid_clamped = PID_LIM;
        end else if (pid_reg < -PID_LIM) begin
            pid_clamped = -PID_LIM;
        end else begin
            pid_clamped = pid_reg;
        end
        pid_mag = pid_clamped[PID_W-1] ? PID_W'(-pid_clamped) : PID_W'(pid_clamped);
    end

    // shift-add multiply step and restoring divide step
    logic [ACC_W-1:0]  mul_acc;
    logic [DVSR_W:0]   div_trial;
    logic [DVSR_W:0]   div_sub;
    logic              div_ge;
    logic [DVSR_W-1:0] div_rem;
    logic [DIV_W-1:0]  div_q;
    logic [RPM_W-1:0]  rpm_eff;
    logic [DVSR_W-1:0] rpm5;
    logic signed [40:0] spd_diff;
    logic [OPA_W-1:0]  spd_mag;

    always_comb begin
        mul_acc = (acc_reg << 1) + (opb_reg[KW_W-1] ? ACC_W'(opa_reg) : '0);
        div_trial = {rem_reg, acc_reg[DIV_W-1]};
        div_sub = div_trial - {1'b0, dvsr_reg};
        div_ge = (div_trial >= {1'b0, dvsr_reg});
        div_rem = div_ge ? div_sub[DVSR_W-1:0] : div_trial[DVSR_W-1:0];
        div_q = {acc_reg[DIV_W-2:0], div_ge};
        rpm_eff = (rpm_reg == '0) ? RPM_W'(1) : rpm_reg;
        rpm5 = ({3'b000, rpm_eff} << 2) + {3'b000, rpm_eff};
        // reduced speed factor, 65536000 - |w_q16|
        spd_diff = $signed(SPEED_FULL - {1'b0, div_q});
        spd_mag = spd_diff[40] ? OPA_W'(-spd_diff) : OPA_W'(spd_diff);
    end

    // output formatting
    logic signed [41:0] v_plus_w;
    logic signed [41:0] v_minus_w;
    cmd_t               turn_sat;
    cmd_t               speed_sat;

    always_comb begin
        v_plus_w = 42'(v_reg) + 42'(w_reg);
        v_minus_w = 42'(v_reg) - 42'(w_reg);
        if (w_reg > 32767) begin
            turn_sat = 16'sh7fff;
        end else if (w_reg < -32768) begin
            turn_sat = -16'sh8000;
        end else begin
            turn_sat = w_reg[15:0];
        end
        if (v_reg > 32767) begin
            speed_sat = 16'sh7fff;
        end else if (v_reg < -32768) begin
            speed_sat = -16'sh8000;
        end else begin
            speed_sat = v_reg[15:0];
        end
    end

    logic last_step;
    assign last_step = (cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= TARGET_RESET;
            base_reg     <= BASE_RESET;
            rpm_reg      <= RPM_RESET;
            gain_p_reg   <= GAIN_P_RESET;
            gain_i_reg   <= GAIN_I_RESET;
            gain_d_reg   <= GAIN_D_RESET;
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            prev_err_reg <= '0;
            integ_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_TARGET_HEADING: target_reg <= $signed(cfg_wdata[TGT_W-1:0]);
                    REG_BASE_SPEED:     base_reg   <= cfg_wdata[BASE_W-1:0];
                    REG_MAX_RPM:        rpm_reg    <= cfg_wdata[RPM_W-1:0];
                    REG_GAIN_P:         gain_p_reg <= cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_I:         gain_i_reg <= cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_D:         gain_d_reg <= cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        prev_err_reg <= err;
                        integ_reg    <= integ_new;
                        e40_reg      <= ({{6{err[15]}}, err} <<< 5)
                                      + ({{6{err[15]}}, err} <<< 3);
                        d40_reg      <= ({{5{deriv[10]}}, deriv} <<< 5)
                                      + ({{5{deriv[10]}}, deriv} <<< 3);
                        pid_reg      <= '0;
                        cnt_reg      <= CNT_W'(GAIN_W - 1);
                        state_reg    <= ST_PID;
                    end
                end
                ST_PID: begin
                    pid_reg <= pid_step;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (last_step) begin
                        state_reg <= ST_PCLAMP;
                    end
                end
                ST_PCLAMP: begin
                    // |pid| * KW, sign carried aside
                    neg_w_reg <= pid_clamped[PID_W-1];
                    opa_reg   <= OPA_W'(pid_mag);
                    opb_reg   <= KW_Q16;
                    acc_reg   <= '0;
                    cnt_reg   <= CNT_W'(KW_W - 1);
                    state_reg <= ST_MUL1;
                end
                ST_MUL1: begin
                    acc_reg <= mul_acc;
                    opb_reg <= opb_reg << 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (last_step) begin
                        acc_reg   <= ACC_W'(mul_acc[DIV_W-1+PROD_SHIFT:PROD_SHIFT]);
                        rem_reg   <= '0;
                        dvsr_reg  <= rpm5;
                        cnt_reg   <= CNT_W'(DIV_W - 1);
                        state_reg <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    acc_reg <= {acc_reg[ACC_W-1:DIV_W], div_q};
                    rem_reg <= div_rem;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (last_step) begin
                        // div_q is |w_q16|
                        w_reg     <= neg_w_reg ? -$signed({1'b0, div_q[DIV_W-1:16]})
                                               : $signed({1'b0, div_q[DIV_W-1:16]});
                        neg_v_reg <= spd_diff[40];
                        opa_reg   <= spd_mag;
                        opb_reg   <= {base_reg, {(KW_W - BASE_W){1'b0}}};
                        acc_reg   <= '0;
                        cnt_reg   <= CNT_W'(BASE_W - 1);
                        state_reg <= ST_MUL2;
                    end
                end
                ST_MUL2: begin
                    acc_reg <= mul_acc;
                    opb_reg <= opb_reg << 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (last_step) begin
                        // divide by 64000 = 2^9 * 125
                        acc_reg   <= ACC_W'(mul_acc[DIV_W+8:9]);
                        rem_reg   <= '0;
                        dvsr_reg  <= V0_DIVISOR;
                        cnt_reg   <= CNT_W'(DIV_W - 1);
                        state_reg <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    acc_reg <= {acc_reg[ACC_W-1:DIV_W], div_q};
                    rem_reg <= div_rem;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (last_step) begin
                        opa_reg   <= div_q;
                        opb_reg   <= {KV_Q8, {(KW_W - KV_W){1'b0}}};
                        acc_reg   <= '0;
                        cnt_reg   <= CNT_W'(KV_W - 1);
                        state_reg <= ST_MUL3;
                    end
                end
                ST_MUL3: begin
                    acc_reg <= mul_acc;
                    opb_reg <= opb_reg << 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (last_step) begin
                        acc_reg   <= ACC_W'(mul_acc[ACC_W-1:28]);
                        rem_reg   <= '0;
                        dvsr_reg  <= DVSR_W'(rpm_eff);
                        cnt_reg   <= CNT_W'(DIV_W - 1);
                        state_reg <= ST_DIV3;
                    end
                end
                ST_DIV3: begin
                    acc_reg <= {acc_reg[ACC_W-1:DIV_W], div_q};
                    rem_reg <= div_rem;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (last_step) begin
                        v_reg     <= neg_v_reg ? -$signed({1'b0, div_q})
                                               : $signed({1'b0, div_q});
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        turn_reg    <= turn_sat;
                        speed_reg   <= speed_sat;
                        over_reg    <= (v_plus_w > SPEED_LIMIT) || (v_minus_w > SPEED_LIMIT);
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_turn_command  = turn_reg;
    assign m_speed_command = speed_reg;
    assign m_overspeed     = over_reg;

endmodule

FILE: rtl/core/hpd_checker.sv
module hpd_props (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [hpd_pkg::CMD_W-1:0]      m_turn_command,
    input logic signed [hpd_pkg::CMD_W-1:0]      m_speed_command,
    input logic                                  m_overspeed
);
    import hpd_pkg::*;

    logic signed [16:0] cmd_sum;
    logic signed [16:0] cmd_dif;

    assign cmd_sum = {m_speed_command[15], m_speed_command}
                   + {m_turn_command[15], m_turn_command};
    assign cmd_dif = {m_speed_command[15], m_speed_command}
                   - {m_turn_command[15], m_turn_command};

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_turn_command)
            && $stable(m_speed_command) && $stable(m_overspeed))
        else $error("result beat changed while stalled");

    // one sample in flight: no input taken right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // a result never appears the cycle after an accept
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared too early");

    // saturated commands above the limit imply the flag
    a_overspeed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (cmd_sum > SPEED_LIMIT || cmd_dif > SPEED_LIMIT) |-> m_overspeed)
        else $error("overspeed flag missing");

endmodule

bind heading_pid_differential_drive hpd_props u_hpd_props (.*);

FILE: verif/hpd_checker.sv
module hpd_checker
    import hpd_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic signed [YAW_W-1:0]      s_yaw,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic signed [CMD_W-1:0]      m_turn_command,
    input  logic signed [CMD_W-1:0]      m_speed_command,
    input  logic                         m_overspeed,
    output int                           fail_count,
    output int                           pending
);

    localparam longint TURN_GEOM  = 564892008;
    localparam longint SPEED_GEOM = 358726115;
    localparam longint FULL_SPEED = 65536000;

    typedef struct packed {
        logic signed [CMD_W-1:0] turn;
        logic signed [CMD_W-1:0] speed;
        logic                    over;
    } cmd_beat_t;

    cmd_beat_t expected_cmds[$];

    longint target, base, rpm, kp, ki, kd;
    longint last_err, err_sum;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic longint clampl(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic logic signed [CMD_W-1:0] sat16(longint x);
        longint c;
        c = clampl(x, -32768, 32767);
        return c[CMD_W-1:0];
    endfunction

    // one control step, advances the stored error and integral
    function automatic cmd_beat_t predict_commands(longint yaw);
        longint e, d, integ, pid, lim, scale, r, w_q, aw, v0, v, w;
        cmd_beat_t res;
        e = yaw - target;
        if (e > HALF_TURN) e -= FULL_TURN;
        else if (e < -HALF_TURN) e += FULL_TURN;
        e = clampl(e, -32768, 32767);
        d = clampl(20 * (e - last_err), -DERIV_LIM, DERIV_LIM);
        integ = clampl(err_sum + e + last_err, -INTEG_LIM, INTEG_LIM);
        last_err = e;
        err_sum = integ;
        scale = longint'(1) << GAIN_FRAC_BITS;
        pid = 40 * kp * e + ki * integ + 40 * kd * d;
        lim = 20 * 2560 * scale;
        pid = clampl(pid, -lim, lim);
        r = (rpm == 0) ? 1 : rpm;
        w_q = pid * TURN_GEOM / (2560 * scale * r);
        aw = w_q < 0 ? -w_q : w_q;
        v0 = base * (FULL_SPEED - aw) / 64000;
        v = v0 * SPEED_GEOM / ((longint'(1) << 28) * r);
        w = w_q / 65536;
        res.turn  = sat16(w);
        res.speed = sat16(v);
        res.over  = ((v + w) > SPEED_LIMIT) || ((v - w) > SPEED_LIMIT);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        cmd_beat_t want;
        if (!aresetn) begin
            target   = TARGET_RESET;
            base     = BASE_RESET;
            rpm      = RPM_RESET;
            kp       = GAIN_P_RESET;
            ki       = GAIN_I_RESET;
            kd       = GAIN_D_RESET;
            last_err = 0;
            err_sum  = 0;
            expected_cmds.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TARGET_HEADING: target = longint'($signed(cfg_wdata));
                    REG_BASE_SPEED:     base = cfg_wdata[BASE_W-1:0];
                    REG_MAX_RPM:        rpm = cfg_wdata[RPM_W-1:0];
                    REG_GAIN_P:         kp = cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_I:         ki = cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_D:         kd = cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_cmds.push_back(predict_commands(longint'(s_yaw)));
            if (m_valid && m_ready) begin
                if (expected_cmds.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = expected_cmds.pop_front();
                    if (m_turn_command !== want.turn)
                        report_mismatch("turn_command", m_turn_command, want.turn);
                    if (m_speed_command !== want.speed)
                        report_mismatch("speed_command", m_speed_command, want.speed);
                    if (m_overspeed !== want.over)
                        report_mismatch("overspeed", m_overspeed, want.over);
                end
            end
        end
        pending = expected_cmds.size();
    end

endmodule

FILE: verif/tb_heading_pid_differential_drive.sv
module tb_heading_pid_differential_drive;
    import hpd_pkg::*;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [YAW_W-1:0]    s_yaw;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [CMD_W-1:0]    m_turn_command;
    logic signed [CMD_W-1:0]    m_speed_command;
    logic                       m_overspeed;
    int                         fail_count;
    int                         pending;

    // idling on both sides is off during some phases
    bit                         idle_on;
    int                         walk_yaw;
    int                         cur_target;

    localparam int PHASES      = 10;
    localparam int BEATS_PHASE = 143;
    localparam int TAIL_CYCLES = 230;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    heading_pid_differential_drive dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_yaw           (s_yaw),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_turn_command  (m_turn_command),
        .m_speed_command (m_speed_command),
        .m_overspeed     (m_overspeed)
    );

    hpd_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_yaw           (s_yaw),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_turn_command  (m_turn_command),
        .m_speed_command (m_speed_command),
        .m_overspeed     (m_overspeed),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // hard stop in case the block hangs
    initial begin
        #4000000;
        $display("tb_heading_pid_differential_drive: errors");
        $finish;
    end

    // result side: random stall before each beat while idling is on, then hold ready until taken
    initial begin
        int  stall;
        bit  seen;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(0, 14) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            // a beat is taken at the rising edge where valid and ready meet
            do begin
                @(posedge aclk);
                seen = m_valid && m_ready;
            end while (!seen);
            @(negedge aclk);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(negedge aclk);
    endtask

    task automatic load_settings(int tgt, int base, int rpm, int kp, int ki, int kd);
        write_reg(REG_TARGET_HEADING, tgt);
        write_reg(REG_BASE_SPEED, base);
        write_reg(REG_MAX_RPM, rpm);
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        cfg_wr_en <= 1'b0;
        cur_target = tgt;
        @(negedge aclk);
    endtask

    // one yaw beat, with a random gap afterwards while idling is on
    task automatic send_yaw(int yaw);
        int gap;
        bit taken;
        s_valid <= 1'b1;
        s_yaw   <= yaw[YAW_W-1:0];
        do begin
            @(posedge aclk);
            taken = s_ready;
        end while (!taken);
        @(negedge aclk);
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (pending != 0 && guard < 20000) begin
            @(negedge aclk);
            guard++;
        end
    endtask

    function automatic int pick_range(int lo, int hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    // mostly smooth heading walks, some jumps, near-wrap and raw 16-bit noise
    function automatic int next_yaw();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) begin
            walk_yaw += int'($urandom_range(0, 400)) - 200;
            if (walk_yaw > 23040) walk_yaw = 23040;
            if (walk_yaw < -23040) walk_yaw = -23040;
        end else if (k < 75) begin
            walk_yaw = int'($urandom_range(0, 46080)) - 23040;
        end else if (k < 88) begin
            // around the half-turn wrap of the error
            walk_yaw = cur_target + ($urandom_range(0, 1) ? 11520 : -11520)
                       + int'($urandom_range(0, 4)) - 2;
        end else begin
            return int'($urandom_range(0, 65535)) - 32768;
        end
        return walk_yaw;
    endfunction

    initial begin
        int dir_a[] = '{0, 640, 32767, -32768, 12160, 12161, -10880, -10881,
                        23040, -23040, 700, 600};
        int dir_b[] = '{32767, -32768, 0, 32767, -100, 100, -32768, 5000};
        int guard;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_yaw     = '0;
        idle_on   = 1'b1;
        walk_yaw  = 0;
        cur_target = 640;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: wrap edges and extremes under reset settings
        foreach (dir_a[i]) send_yaw(dir_a[i]);
        s_valid <= 1'b0;
        wait_drained();

        // directed: saturating error, zero max rpm, full gains and speed
        load_settings(-32768, 8191, 0, 4095, 4095, 4095);
        foreach (dir_b[i]) send_yaw(dir_b[i]);
        s_valid <= 1'b0;
        wait_drained();
        load_settings(23040, 4096, 100, 0, 0, 0);
        send_yaw(-32768);
        send_yaw(32767);
        s_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            idle_on = (p % 3) != 1;
            case (p)
                0: load_settings(0, 4096, 65535, 4095, 4095, 4095);
                1: load_settings(-23040, 0, 100, 0, 4095, 0);
                2: load_settings(23040, 8191, 1, 282, 26, 179);
                default:
                    load_settings(pick_range(-23040, 23040), pick_range(0, 4096),
                                  $urandom_range(0, 3) == 0 ? pick_range(0, 200)
                                                            : pick_range(100, 65535),
                                  pick_range(0, 4095), pick_range(0, 4095),
                                  pick_range(0, 4095));
            endcase
            walk_yaw = cur_target;
            for (int n = 0; n < BEATS_PHASE; n++) send_yaw(next_yaw());
            s_valid <= 1'b0;
            wait_drained();
        end

        guard = 0;
        while (pending != 0 && guard < 20000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("tb_heading_pid_differential_drive: clean");
        else
            $display("tb_heading_pid_differential_drive: errors");
        $finish;
    end

endmodule
